// ===== hdl/iwbm_pkg.sv =====
// Shared types, constants and codes of the isolation window best match block.
`default_nettype none
package iwbm_pkg;

  localparam int unsigned MAX_WINDOWS_DEF = 32;

  localparam int unsigned MZ_W     = 32;
  localparam int unsigned IM_W     = 25;
  localparam int unsigned MWIN_W   = 24;
  localparam int unsigned WIU_W    = 6;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned DIST_W   = 27;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_EDGE   = 2'd0,
    CFG_CLOSED_UB  = 2'd1,
    CFG_MOB_WINDOW = 2'd2,
    CFG_WIN_IN_USE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // One table entry as held in the window memory.
  typedef struct packed {
    logic [MZ_W-1:0]        mz_low;
    logic [MZ_W-1:0]        mz_high;
    logic signed [IM_W-1:0] im_low;
    logic signed [IM_W-1:0] im_high;
    logic                   is_ms1;
  } entry_t;

  // Match settings seen by the entry evaluator.
  typedef struct packed {
    logic [MZ_W-1:0]   min_edge;
    logic              closed_ub;
    logic [MWIN_W-1:0] mob_window;
  } match_cfg_t;

  // Registered verdict for one entry.
  typedef struct packed {
    logic              vld;
    logic              acc;
    logic [DIST_W-1:0] delta;
  } verdict_t;

endpackage
`default_nettype wire

// ===== hdl/iwbm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module iwbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/iwbm_eval.sv =====
// Entry evaluator: match test and mobility-centre distance, registered.
`default_nettype none
module iwbm_eval #(
  parameter int unsigned AW = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic [AW-1:0]                 idx_i,
  input  wire iwbm_pkg::entry_t              entry_i,
  input  wire iwbm_pkg::match_cfg_t          cfg_i,
  input  wire logic [iwbm_pkg::MZ_W-1:0]     qmz_i,
  input  wire logic signed [iwbm_pkg::IM_W-1:0] qim_i,
  output iwbm_pkg::verdict_t                 verdict_o,
  output logic [AW-1:0]                      idx_o
);
  import iwbm_pkg::*;

  logic                    mz_ok;
  logic                    im_ok;
  logic                    acc;
  logic signed [26:0]      q2;
  logic signed [26:0]      lo2;
  logic signed [26:0]      hi2;
  logic signed [26:0]      w27;
  logic signed [26:0]      q_plus_w;
  logic signed [26:0]      q_minus_w;
  logic signed [27:0]      dsum;
  logic [DIST_W-1:0]       delta;
  verdict_t                verdict_d;
  verdict_t                verdict_q;
  logic [AW-1:0]           idx_q;

  always_comb begin
    // Doubled mobility values avoid halving the extraction width.
    q2        = {qim_i[IM_W-1], qim_i, 1'b0};
    lo2       = {entry_i.im_low[IM_W-1], entry_i.im_low, 1'b0};
    hi2       = {entry_i.im_high[IM_W-1], entry_i.im_high, 1'b0};
    w27       = $signed({3'b000, cfg_i.mob_window});
    q_plus_w  = q2 + w27;
    q_minus_w = q2 - w27;

    mz_ok = (entry_i.mz_low < qmz_i) &&
            (cfg_i.closed_ub ? (qmz_i <= entry_i.mz_high) : (qmz_i < entry_i.mz_high)) &&
            ((entry_i.mz_high - qmz_i) >= cfg_i.min_edge);

    if (cfg_i.mob_window == '0) begin
      im_ok = (entry_i.im_low < qim_i) &&
              (cfg_i.closed_ub ? (qim_i <= entry_i.im_high) : (qim_i < entry_i.im_high));
    end else begin
      im_ok = (q_plus_w > lo2) && (q_minus_w < hi2);
    end

    acc = !entry_i.is_ms1 && (qmz_i != '0) && !qim_i[IM_W-1] &&
          !entry_i.im_low[IM_W-1] && !entry_i.im_high[IM_W-1] && mz_ok && im_ok;

    dsum  = 28'(lo2 >>> 1) + 28'(hi2 >>> 1) - 28'(q2);
    delta = dsum[27] ? DIST_W'(-dsum) : DIST_W'(dsum);

    verdict_d.vld   = vld_i;
    verdict_d.acc   = vld_i && acc;
    verdict_d.delta = delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q <= '0;
    end else begin
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_i;
  end

  assign verdict_o = verdict_q;
  assign idx_o     = idx_q;

endmodule
`default_nettype wire

// ===== hdl/isolation_window_best_match.sv =====
// Top level: window table memory, scan sequencer, best-match tracking, result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | action, entry_index, load_*, query_*
//   out     | source    | out_valid_o / out_stall_i | found, best_entry
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load transfer writes the window memory in its own cycle; the next item is taken
// in the following cycle. A query reads one table entry per cycle through the single
// memory read port, N entries in all, N being windows_in_use capped at MAX_WINDOWS,
// and holds off new items from its transfer until its result lands in the output
// register. Reset clears control and configuration only; the table is not cleared
// and entries read before being written give arbitrary results. A stalled result
// holds in the output register; a finished scan waits for that register to drain.
`default_nettype none
module isolation_window_best_match #(
  parameter int unsigned MAX_WINDOWS = iwbm_pkg::MAX_WINDOWS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // item input
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 action_i,
  input  wire logic [iwbm_pkg::ENTRY_W-1:0]         entry_index_i,
  input  wire logic [iwbm_pkg::MZ_W-1:0]            load_mz_low_i,
  input  wire logic [iwbm_pkg::MZ_W-1:0]            load_mz_high_i,
  input  wire logic signed [iwbm_pkg::IM_W-1:0]     load_im_low_i,
  input  wire logic signed [iwbm_pkg::IM_W-1:0]     load_im_high_i,
  input  wire logic                                 load_is_ms1_i,
  input  wire logic [iwbm_pkg::MZ_W-1:0]            query_mz_i,
  input  wire logic signed [iwbm_pkg::IM_W-1:0]     query_im_i,
  // result output
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      found_o,
  output logic [iwbm_pkg::ENTRY_W-1:0]              best_entry_o,
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [iwbm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [iwbm_pkg::CFG_DAT_W-1:0]       cfg_data_i
);
  import iwbm_pkg::*;

  localparam int unsigned AW    = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1);

  // configuration registers
  logic [MZ_W-1:0]   min_edge_q;
  logic              closed_ub_q;
  logic [MWIN_W-1:0] mob_window_q;
  logic [WIU_W-1:0]  win_in_use_q;
  match_cfg_t        match_cfg;

  // sequencer state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [MZ_W-1:0]   qmz_q;
  logic signed [IM_W-1:0] qim_q;

  // best-match tracking
  logic              found_q, found_d;
  logic [AW-1:0]     best_q, best_d;
  logic [DIST_W-1:0] best_dist_q, best_dist_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [AW-1:0]     out_best_q, out_best_d;

  // memory and evaluator
  logic              in_xfer;
  logic              query_start;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  entry_t            wentry;
  entry_t            rentry;
  verdict_t          verdict;
  logic [AW-1:0]     ev_idx;
  logic [CNT_W-1:0]  cnt_sat;

  assign cfg_ready_o = 1'b1;

  // The user must write config only while idle; the block itself does not guard against a running scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_edge_q   <= '0;
      closed_ub_q  <= 1'b0;
      mob_window_q <= '0;
      win_in_use_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_EDGE:   min_edge_q   <= cfg_data_i;
        CFG_CLOSED_UB:  closed_ub_q  <= cfg_data_i[0];
        CFG_MOB_WINDOW: mob_window_q <= cfg_data_i[MWIN_W-1:0];
        CFG_WIN_IN_USE: win_in_use_q <= cfg_data_i[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign match_cfg.min_edge   = min_edge_q;
  assign match_cfg.closed_ub  = closed_ub_q;
  assign match_cfg.mob_window = mob_window_q;

  // Cap the scan length at the table depth.
  assign cnt_sat = (32'(win_in_use_q) > 32'(MAX_WINDOWS)) ? CNT_W'(MAX_WINDOWS)
                                                          : CNT_W'(win_in_use_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign query_start = in_xfer && (action_e'(action_i) == ACT_QUERY);

  // Drop loads whose index lies beyond the table.
  assign mem_we = in_xfer && (action_e'(action_i) == ACT_LOAD) &&
                  (32'(entry_index_i) < 32'(MAX_WINDOWS));

  assign wentry.mz_low  = load_mz_low_i;
  assign wentry.mz_high = load_mz_high_i;
  assign wentry.im_low  = load_im_low_i;
  assign wentry.im_high = load_im_high_i;
  assign wentry.is_ms1  = load_is_ms1_i;

  iwbm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_WINDOWS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i (wentry),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rentry)
  );

  iwbm_eval #(
    .AW (AW)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (rd_vld_q),
    .idx_i     (rd_idx_q),
    .entry_i   (rentry),
    .cfg_i     (match_cfg),
    .qmz_i     (qmz_q),
    .qim_i     (qim_q),
    .verdict_o (verdict),
    .idx_o     (ev_idx)
  );

  // Sequencer: issue reads, fold verdicts into the running best, hand off the result.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    mem_re      = 1'b0;
    mem_raddr   = iss_q[AW-1:0];
    found_d     = found_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_best_d  = out_best_q;

    // Keep the earliest entry on a tie: replace only on a strictly smaller distance.
    if (verdict.vld && verdict.acc && (!found_q || (verdict.delta < best_dist_q))) begin
      found_d     = 1'b1;
      best_d      = ev_idx;
      best_dist_d = verdict.delta;
    end

    unique case (state_q)
      S_IDLE: begin
        if (query_start) begin
          cnt_d       = cnt_sat;
          iss_d       = '0;
          found_d     = 1'b0;
          best_d      = '0;
          best_dist_d = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_q < cnt_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q[AW-1:0];
          iss_d    = iss_q + CNT_W'(1);
        end else if (!rd_vld_q && !verdict.vld) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_best_d  = found_q ? best_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      cnt_q       <= '0;
      iss_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      best_q      <= best_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_dist_q <= best_dist_d;
    out_found_q <= out_found_d;
    out_best_q  <= out_best_d;
    if (query_start) begin
      qmz_q <= query_mz_i;
      qim_q <= query_im_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign best_entry_o = ENTRY_W'(out_best_q);

  // Reads in flight only belong to a running scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || verdict.vld) |-> (state_q == S_SCAN))
    else $error("table read in flight outside a scan");

  // The issue pointer never passes the scan length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (iss_q <= cnt_q))
    else $error("issue pointer beyond scan length");

  // Every entry read lies inside the scanned range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CNT_W'(rd_idx_q) < cnt_q))
    else $error("entry read outside scanned range");

  // A new result only comes from the finishing step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result raised outside finish step");

  // A not-found result carries entry zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_best_q == '0))
    else $error("not-found result with nonzero entry");

endmodule
`default_nettype wire
